// ===== src/tcs_pkg.sv =====
// Shared types, constants and helpers for the triangle contour slicer.
package tcs_pkg;

   localparam int NUM_EDGES   = 3;
   localparam int NUM_LANES   = 4;
   localparam int DIV_BITS    = 32;
   localparam int LANE_STAGES = DIV_BITS + 2;
   localparam int FRONT_STAGES = 2;
   localparam int PIPE_STAGES = FRONT_STAGES + LANE_STAGES;

   // lane order in the result word
   localparam int LANE_START_X = 0;
   localparam int LANE_START_Y = 1;
   localparam int LANE_END_X   = 2;
   localparam int LANE_END_Y   = 3;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [32:0] diff_type;
   typedef logic        [31:0] mag_type;

   typedef struct packed {
      coord_type vert0_x;
      coord_type vert0_y;
      coord_type vert0_z;
      coord_type vert1_x;
      coord_type vert1_y;
      coord_type vert1_z;
      coord_type vert2_x;
      coord_type vert2_y;
      coord_type vert2_z;
      coord_type level;
   } tri_type;

   typedef struct packed {
      mag_type   num_mag;
      mag_type   den_mag;
      mag_type   dp_mag;
      logic      dp_neg;
      coord_type base;
   } lane_op_type;

   function automatic diff_type sx(input coord_type v);
      return {v[31], v};
   endfunction

   function automatic mag_type abs33(input diff_type v);
      diff_type n;
      n = -v;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

endpackage

// ===== src/tcs_channels.sv =====
// Valid/ready channel interfaces for triangle words and segment words.
interface tcs_req_if;
   logic                 valid;
   logic                 ready;
   tcs_pkg::coord_type   vert0_x;
   tcs_pkg::coord_type   vert0_y;
   tcs_pkg::coord_type   vert0_z;
   tcs_pkg::coord_type   vert1_x;
   tcs_pkg::coord_type   vert1_y;
   tcs_pkg::coord_type   vert1_z;
   tcs_pkg::coord_type   vert2_x;
   tcs_pkg::coord_type   vert2_y;
   tcs_pkg::coord_type   vert2_z;
   tcs_pkg::coord_type   level;

   modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                   vert2_x, vert2_y, vert2_z, level, input ready);
   modport sink   (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                   vert2_x, vert2_y, vert2_z, level, output ready);
endinterface

interface tcs_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 seg_valid;
   tcs_pkg::coord_type   start_x;
   tcs_pkg::coord_type   start_y;
   tcs_pkg::coord_type   end_x;
   tcs_pkg::coord_type   end_y;
   tcs_pkg::coord_type   seg_level;

   modport source (output valid, seg_valid, start_x, start_y, end_x, end_y, seg_level,
                   input ready);
   modport sink   (input valid, seg_valid, start_x, start_y, end_x, end_y, seg_level,
                   output ready);
endinterface

// ===== src/tcs_front.sv =====
// Front end: edge differences, crossing test and operand selection per lane.
module tcs_front (
   input  logic                                          clock,
   input  logic                                          load0,
   input  logic                                          load1,
   input  tcs_pkg::tri_type                              tri_in,
   output tcs_pkg::lane_op_type [tcs_pkg::NUM_LANES-1:0] ops,
   output logic                                          seg_ok,
   output tcs_pkg::coord_type                            level_out
);

   tcs_pkg::diff_type  lz_ff [tcs_pkg::NUM_EDGES];
   tcs_pkg::diff_type  dz_ff [tcs_pkg::NUM_EDGES];
   tcs_pkg::diff_type  dx_ff [tcs_pkg::NUM_EDGES];
   tcs_pkg::diff_type  dy_ff [tcs_pkg::NUM_EDGES];
   tcs_pkg::coord_type bx_ff [tcs_pkg::NUM_EDGES];
   tcs_pkg::coord_type by_ff [tcs_pkg::NUM_EDGES];
   tcs_pkg::coord_type lvl0_ff;

   tcs_pkg::lane_op_type [tcs_pkg::NUM_LANES-1:0] ops_ff, ops_in;
   logic                                          ok_ff, ok_in;
   tcs_pkg::coord_type                            lvl1_ff;

   tcs_pkg::coord_type vx [tcs_pkg::NUM_EDGES];
   tcs_pkg::coord_type vy [tcs_pkg::NUM_EDGES];
   tcs_pkg::coord_type vz [tcs_pkg::NUM_EDGES];

   assign vx[0] = tri_in.vert0_x;
   assign vy[0] = tri_in.vert0_y;
   assign vz[0] = tri_in.vert0_z;
   assign vx[1] = tri_in.vert1_x;
   assign vy[1] = tri_in.vert1_y;
   assign vz[1] = tri_in.vert1_z;
   assign vx[2] = tri_in.vert2_x;
   assign vy[2] = tri_in.vert2_y;
   assign vz[2] = tri_in.vert2_z;

   // stage 0: level offsets and edge deltas
   for (genvar i = 0; i < tcs_pkg::NUM_EDGES; i++) begin : g_edge
      localparam int J = (i == tcs_pkg::NUM_EDGES - 1) ? 0 : i + 1;
      always_ff @(posedge clock) begin
         if (load0) begin
            lz_ff[i] <= tcs_pkg::sx(tri_in.level) - tcs_pkg::sx(vz[i]);
            dz_ff[i] <= tcs_pkg::sx(vz[J]) - tcs_pkg::sx(vz[i]);
            dx_ff[i] <= tcs_pkg::sx(vx[J]) - tcs_pkg::sx(vx[i]);
            dy_ff[i] <= tcs_pkg::sx(vy[J]) - tcs_pkg::sx(vy[i]);
            bx_ff[i] <= vx[i];
            by_ff[i] <= vy[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load0) begin
         lvl0_ff <= tri_in.level;
      end
   end

   // stage 1: crossing flags, pick the two crossed edges
   always_comb begin
      logic [tcs_pkg::NUM_EDGES-1:0] above, below, hit;
      logic [1:0]                    first_e, second_e;
      for (int i = 0; i < tcs_pkg::NUM_EDGES; i++) begin
         // level - z > 0 means the vertex lies below the level
         below[i] = !lz_ff[i][32] && (lz_ff[i] != '0);
         above[i] = lz_ff[i][32];
      end
      hit[0]   = (below[0] && above[1]) || (above[0] && below[1]);
      hit[1]   = (below[1] && above[2]) || (above[1] && below[2]);
      hit[2]   = (below[2] && above[0]) || (above[2] && below[0]);
      ok_in    = ($countones(hit) == 2);
      first_e  = hit[0] ? 2'd0 : 2'd1;
      second_e = hit[2] ? 2'd2 : 2'd1;

      ops_in[tcs_pkg::LANE_START_X].num_mag = tcs_pkg::abs33(lz_ff[first_e]);
      ops_in[tcs_pkg::LANE_START_X].den_mag = tcs_pkg::abs33(dz_ff[first_e]);
      ops_in[tcs_pkg::LANE_START_X].dp_mag  = tcs_pkg::abs33(dx_ff[first_e]);
      ops_in[tcs_pkg::LANE_START_X].dp_neg  = dx_ff[first_e][32];
      ops_in[tcs_pkg::LANE_START_X].base    = bx_ff[first_e];

      ops_in[tcs_pkg::LANE_START_Y].num_mag = tcs_pkg::abs33(lz_ff[first_e]);
      ops_in[tcs_pkg::LANE_START_Y].den_mag = tcs_pkg::abs33(dz_ff[first_e]);
      ops_in[tcs_pkg::LANE_START_Y].dp_mag  = tcs_pkg::abs33(dy_ff[first_e]);
      ops_in[tcs_pkg::LANE_START_Y].dp_neg  = dy_ff[first_e][32];
      ops_in[tcs_pkg::LANE_START_Y].base    = by_ff[first_e];

      ops_in[tcs_pkg::LANE_END_X].num_mag   = tcs_pkg::abs33(lz_ff[second_e]);
      ops_in[tcs_pkg::LANE_END_X].den_mag   = tcs_pkg::abs33(dz_ff[second_e]);
      ops_in[tcs_pkg::LANE_END_X].dp_mag    = tcs_pkg::abs33(dx_ff[second_e]);
      ops_in[tcs_pkg::LANE_END_X].dp_neg    = dx_ff[second_e][32];
      ops_in[tcs_pkg::LANE_END_X].base      = bx_ff[second_e];

      ops_in[tcs_pkg::LANE_END_Y].num_mag   = tcs_pkg::abs33(lz_ff[second_e]);
      ops_in[tcs_pkg::LANE_END_Y].den_mag   = tcs_pkg::abs33(dz_ff[second_e]);
      ops_in[tcs_pkg::LANE_END_Y].dp_mag    = tcs_pkg::abs33(dy_ff[second_e]);
      ops_in[tcs_pkg::LANE_END_Y].dp_neg    = dy_ff[second_e][32];
      ops_in[tcs_pkg::LANE_END_Y].base      = by_ff[second_e];
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         ops_ff  <= ops_in;
         ok_ff   <= ok_in;
         lvl1_ff <= lvl0_ff;
      end
   end

   assign ops       = ops_ff;
   assign seg_ok    = ok_ff;
   assign level_out = lvl1_ff;

endmodule

// ===== src/tcs_lane.sv =====
// One interpolation lane: 32x32 product, bit-per-stage divider, final add.
module tcs_lane (
   input  logic                                clock,
   input  logic [tcs_pkg::LANE_STAGES-1:0]     load,
   input  tcs_pkg::lane_op_type                op,
   input  logic                                seg_ok,
   output tcs_pkg::coord_type                  result
);

   localparam int NB = tcs_pkg::DIV_BITS;

   // index 0 is the product stage, 1..NB the divider steps
   logic [31:0]        rem_ff  [NB+1];
   logic [31:0]        low_ff  [NB+1];
   logic [31:0]        quo_ff  [NB+1];
   logic [31:0]        den_ff  [NB+1];
   logic               neg_ff  [NB+1];
   logic               ok_ff   [NB+1];
   tcs_pkg::coord_type base_ff [NB+1];
   tcs_pkg::coord_type res_ff;

   logic [63:0] prod;
   assign prod = 64'(op.num_mag) * 64'(op.dp_mag);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rem_ff[0]  <= prod[63:32];
         low_ff[0]  <= prod[31:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= op.den_mag;
         neg_ff[0]  <= op.dp_neg;
         ok_ff[0]   <= seg_ok;
         base_ff[0] <= op.base;
      end
   end

   for (genvar k = 0; k < NB; k++) begin : g_div
      logic [32:0] trial, diff;
      logic        ge;
      assign trial = {rem_ff[k], low_ff[k][31]};
      assign diff  = trial - {1'b0, den_ff[k]};
      assign ge    = (trial >= {1'b0, den_ff[k]});
      always_ff @(posedge clock) begin
         if (load[k+1]) begin
            rem_ff[k+1]  <= ge ? diff[31:0] : trial[31:0];
            low_ff[k+1]  <= {low_ff[k][30:0], 1'b0};
            quo_ff[k+1]  <= {quo_ff[k][30:0], ge};
            den_ff[k+1]  <= den_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            ok_ff[k+1]   <= ok_ff[k];
            base_ff[k+1] <= base_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[NB+1]) begin
         if (!ok_ff[NB]) begin
            res_ff <= '0;
         end else if (neg_ff[NB]) begin
            res_ff <= base_ff[NB] - $signed(quo_ff[NB]);
         end else begin
            res_ff <= base_ff[NB] + $signed(quo_ff[NB]);
         end
      end
   end

   assign result = res_ff;

endmodule

// ===== src/triangle_contour_slicer.sv =====
// Top level of the triangle contour slicer: front end, four lanes, flow control.
//
// Usage notes
//  - req_ch carries one triangle word: three vertices (x, y, z) and a level,
//    all signed Q23.8. rsp_ch returns one segment word per triangle, in order.
//  - A segment is valid when exactly two of the edges a-b, b-c, c-a cross the
//    level strictly; start is the crossing on the earlier edge, end the later.
//    With no segment every result field reads zero.
//  - A word passes 36 register stages: two front-end stages, one multiply
//    stage, 32 divider stages (one quotient bit each) and the output register.
//  - Throughput is one word per cycle while rsp_ch.ready is high; the 32-stage
//    divider in each of the four lanes is fully pipelined.
//  - Reset clears every stage valid bit; no words are held afterwards.
//  - When the receiver stalls, the output register holds its word and the
//    stages behind it keep filling any empty slots, so req_ch.ready stays high
//    until every stage holds a word.
module triangle_contour_slicer (
   input logic       clock,
   input logic       reset,
   tcs_req_if.sink   req_ch,
   tcs_rsp_if.source rsp_ch
);

   localparam int NS = tcs_pkg::PIPE_STAGES;
   localparam int FS = tcs_pkg::FRONT_STAGES;
   localparam int LS = tcs_pkg::LANE_STAGES;

   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] load;

   tcs_pkg::tri_type                              tri_word;
   tcs_pkg::lane_op_type [tcs_pkg::NUM_LANES-1:0] ops;
   logic                                          front_ok;
   tcs_pkg::coord_type                            front_level;
   tcs_pkg::coord_type   lane_res [tcs_pkg::NUM_LANES];

   // level and segment flag travel alongside the lanes
   tcs_pkg::coord_type lvl_ff [LS];
   logic               ok_ff  [LS];

   // a stage loads when it is empty or its word moves on this cycle
   always_comb begin
      load[NS-1] = !valid_ff[NS-1] || rsp_ch.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? req_ch.valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = load[0];

   assign tri_word.vert0_x = req_ch.vert0_x;
   assign tri_word.vert0_y = req_ch.vert0_y;
   assign tri_word.vert0_z = req_ch.vert0_z;
   assign tri_word.vert1_x = req_ch.vert1_x;
   assign tri_word.vert1_y = req_ch.vert1_y;
   assign tri_word.vert1_z = req_ch.vert1_z;
   assign tri_word.vert2_x = req_ch.vert2_x;
   assign tri_word.vert2_y = req_ch.vert2_y;
   assign tri_word.vert2_z = req_ch.vert2_z;
   assign tri_word.level   = req_ch.level;

   tcs_front u_front (
      .clock     (clock),
      .load0     (load[0]),
      .load1     (load[1]),
      .tri_in    (tri_word),
      .ops       (ops),
      .seg_ok    (front_ok),
      .level_out (front_level)
   );

   for (genvar l = 0; l < tcs_pkg::NUM_LANES; l++) begin : g_lane
      tcs_lane u_lane (
         .clock  (clock),
         .load   (load[NS-1:FS]),
         .op     (ops[l]),
         .seg_ok (front_ok),
         .result (lane_res[l])
      );
   end

   // side line: flag and level, zeroed at the output when no segment
   always_ff @(posedge clock) begin
      if (load[FS]) begin
         lvl_ff[0] <= front_level;
         ok_ff[0]  <= front_ok;
      end
   end

   for (genvar k = 1; k < LS; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (load[FS+k]) begin
            lvl_ff[k] <= (k == LS - 1 && !ok_ff[k-1]) ? '0 : lvl_ff[k-1];
            ok_ff[k]  <= ok_ff[k-1];
         end
      end
   end

   assign rsp_ch.valid     = valid_ff[NS-1];
   assign rsp_ch.seg_valid = ok_ff[LS-1];
   assign rsp_ch.start_x   = lane_res[tcs_pkg::LANE_START_X];
   assign rsp_ch.start_y   = lane_res[tcs_pkg::LANE_START_Y];
   assign rsp_ch.end_x     = lane_res[tcs_pkg::LANE_END_X];
   assign rsp_ch.end_y     = lane_res[tcs_pkg::LANE_END_Y];
   assign rsp_ch.seg_level = lvl_ff[LS-1];

endmodule
